FILE: rtl/parl_pkg.sv
// ----------------------------------------------------------------------------
// parl_pkg
// Shared types, result codes and the power-of-ten check for the per-address
// event rate limiter.
// ----------------------------------------------------------------------------
package parl_pkg;

    localparam int ADDR_W       = 32;
    localparam int OUTCOME_W    = 2;
    localparam int HIT_TOTAL_W  = 32;
    localparam int ENTRY_SLOT_W = 4;
    localparam int WIDE_W       = 64;

    localparam logic [OUTCOME_W-1:0] OUTCOME_SUPPRESS = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_REPORT   = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_DROP     = 2'd2;

    // Every power of ten that fits in 64 bits.
    localparam int POW10_COUNT = 20;
    localparam logic [WIDE_W-1:0] POW10_TABLE [POW10_COUNT] = '{
        64'd1,
        64'd10,
        64'd100,
        64'd1000,
        64'd10000,
        64'd100000,
        64'd1000000,
        64'd10000000,
        64'd100000000,
        64'd1000000000,
        64'd10000000000,
        64'd100000000000,
        64'd1000000000000,
        64'd10000000000000,
        64'd100000000000000,
        64'd1000000000000000,
        64'd10000000000000000,
        64'd100000000000000000,
        64'd1000000000000000000,
        64'd10000000000000000000
    };

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              look;
        logic              commit;
        logic              any_hit;
    } parl_ctl_t;

    function automatic logic is_pow10(input logic [WIDE_W-1:0] value);
        logic found;
        found = 1'b0;
        for (int k = 0; k < POW10_COUNT; k++)
        begin
            if (value == POW10_TABLE[k])
            begin
                found = 1'b1;
            end
        end
        return found;
    endfunction

endpackage

FILE: rtl/parl_event_if.sv
// ----------------------------------------------------------------------------
// parl_event_if
// Input channel: one event address per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface parl_event_if;
    logic        valid;
    logic        ready;
    logic [31:0] event_address;

    modport source (output valid, output event_address, input ready);
    modport sink   (input valid, input event_address, output ready);
endinterface

FILE: rtl/parl_result_if.sv
// ----------------------------------------------------------------------------
// parl_result_if
// Output channel: one result item per event, valid/ready handshake.
// ----------------------------------------------------------------------------
interface parl_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic [31:0] hit_total;
    logic [3:0]  entry_slot;

    modport source (output valid, output outcome, output hit_total, output entry_slot,
                    input ready);
    modport sink   (input valid, input outcome, input hit_total, input entry_slot,
                    output ready);
endinterface

FILE: rtl/per_address_event_rate_limiter_top.sv
// ----------------------------------------------------------------------------
// per_address_event_rate_limiter_top
// Looks each event address up in a row of table cells, allocates on a miss or
// drops it if the table is full, counts hits and flags exact powers of ten.
// ----------------------------------------------------------------------------
// Flow: an accepted item is compared across all cells in the look state, then
// the selected cell is updated and the result registered in the update state
// once the output is free. A new item is taken in idle or as the last commits.
// The output register decouples the result from the next item's lookup.
// Reset clears the cell occupancy bits and all control; stored addresses and
// counters are not reset and are only read once their cell is occupied.
module per_address_event_rate_limiter_top #(
    parameter int TABLE_SLOTS = 16,
    parameter int HIT_BITS    = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    parl_event_if.sink    events,
    parl_result_if.source results
);
    import parl_pkg::*;

    localparam int IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int SLOT_W = (IDX_W > ENTRY_SLOT_W) ? IDX_W : ENTRY_SLOT_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOK   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [ADDR_W-1:0]       addr_reg;
    logic                    full_reg;
    logic                    full_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [OUTCOME_W-1:0]    outcome_reg;
    logic [HIT_TOTAL_W-1:0]  hit_total_reg;
    logic [ENTRY_SLOT_W-1:0] entry_slot_reg;

    logic                    advance;
    logic                    accept;
    parl_ctl_t               ctl;
    logic [TABLE_SLOTS:0]    used_chain;
    logic [TABLE_SLOTS-1:0]  hits;
    logic [TABLE_SLOTS-1:0]  takes;
    logic [HIT_BITS-1:0]     cnt_vec [TABLE_SLOTS];
    logic [HIT_BITS-1:0]     cnt_sel;
    logic [SLOT_W-1:0]       idx_sel;
    logic [WIDE_W-1:0]       cnt_wide;

    assign advance = (state_reg == ST_UPDATE) && (!out_valid_reg || results.ready);
    assign events.ready = (state_reg == ST_IDLE) || advance;
    assign accept = events.valid && events.ready;

    assign ctl.addr    = addr_reg;
    assign ctl.look    = (state_reg == ST_LOOK);
    assign ctl.commit  = advance;
    assign ctl.any_hit = |hits;

    assign used_chain[0] = 1'b1;

    for (genvar g = 0; g < TABLE_SLOTS; g++)
    begin : g_cell
        parl_cell #(
            .HIT_BITS (HIT_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .prev_used (used_chain[g]),
            .used      (used_chain[g+1]),
            .hit       (hits[g]),
            .take      (takes[g]),
            .cnt_new   (cnt_vec[g])
        );
    end

    // At most one cell takes the item, so an OR merge selects it.
    always_comb
    begin
        cnt_sel = '0;
        idx_sel = '0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (takes[i])
            begin
                cnt_sel = cnt_sel | cnt_vec[i];
                idx_sel = idx_sel | SLOT_W'(i);
            end
        end
    end

    assign cnt_wide = WIDE_W'(cnt_sel);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (advance)
                begin
                    state_next = accept ? ST_LOOK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The table is full only when the last cell is occupied and nothing hit.
    assign full_next = (state_reg == ST_LOOK) ?
                       (!ctl.any_hit && used_chain[TABLE_SLOTS]) : full_reg;

    assign out_valid_next = advance ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= events.event_address;
        end
        if (advance)
        begin
            if (full_reg)
            begin
                outcome_reg    <= OUTCOME_DROP;
                hit_total_reg  <= '0;
                entry_slot_reg <= '0;
            end
            else
            begin
                outcome_reg    <= is_pow10(cnt_wide) ? OUTCOME_REPORT : OUTCOME_SUPPRESS;
                hit_total_reg  <= cnt_wide[HIT_TOTAL_W-1:0];
                entry_slot_reg <= idx_sel[ENTRY_SLOT_W-1:0];
            end
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.outcome    = outcome_reg;
    assign results.hit_total  = hit_total_reg;
    assign results.entry_slot = entry_slot_reg;

endmodule

FILE: rtl/parl_cell.sv
// ----------------------------------------------------------------------------
// parl_cell
// One table entry: stored address, hit counter and occupancy bit. Occupancy
// is handed down the row so that the first free cell knows it is next.
// ----------------------------------------------------------------------------
module parl_cell #(
    parameter int HIT_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  parl_pkg::parl_ctl_t ctl,
    input  logic                prev_used,
    output logic                used,
    output logic                hit,
    output logic                take,
    output logic [HIT_BITS-1:0] cnt_new
);
    import parl_pkg::*;

    localparam logic [HIT_BITS-1:0] CNT_MAX = {HIT_BITS{1'b1}};

    logic [ADDR_W-1:0]   addr_reg;
    logic [HIT_BITS-1:0] cnt_reg;
    logic                used_reg;
    logic                used_next;
    logic                take_reg;
    logic                take_next;

    assign used = used_reg;
    assign take = take_reg;
    assign hit  = used_reg && (addr_reg == ctl.addr);

    // A fresh entry starts at zero, so its first hit makes one.
    assign cnt_new = !used_reg ? HIT_BITS'(1) :
                     (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + HIT_BITS'(1);

    always_comb
    begin
        take_next = take_reg;
        used_next = used_reg;
        if (ctl.look)
        begin
            take_next = hit || (prev_used && !used_reg && !ctl.any_hit);
        end
        if (ctl.commit && take_reg)
        begin
            used_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            take_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            take_reg <= take_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && take_reg)
        begin
            cnt_reg <= cnt_new;
            if (!used_reg)
            begin
                addr_reg <= ctl.addr;
            end
        end
    end

endmodule
